// ===== design/sus_pkg.sv =====
// Shared types, field widths and codes for the sorted unique key set.
package sus_pkg;

  localparam int KEY_BITS   = 16;
  localparam int MODE_BITS  = 2;
  localparam int STAT_BITS  = 3;
  localparam int POS_BITS   = 4;
  localparam int COUNT_BITS = 5;
  localparam int DEPTH_DEF  = 16;

  localparam logic [MODE_BITS-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_SEARCH = 2'd2;

  localparam logic [STAT_BITS-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_BITS-1:0] ST_DUP      = 3'd1;
  localparam logic [STAT_BITS-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [STAT_BITS-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STAT_BITS-1:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    logic [KEY_BITS-1:0]  key;
  } req_t;

  typedef struct packed {
    logic [STAT_BITS-1:0]  status;
    logic [POS_BITS-1:0]   position;
    logic [COUNT_BITS-1:0] count;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

endpackage

// ===== design/sus_ctrl.sv =====
// Request sequencer: accepts a word, runs one update step, manages the result register.
module sus_ctrl (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output sus_pkg::cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic exec_go;

  assign in_ready    = (state_r == S_IDLE);
  assign exec_go     = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.execute = exec_go;
  assign out_valid   = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (cmd.capture) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/sus_dpath.sv =====
// Sorted register chain with parallel compare, shift-insert/delete and result register.
module sus_dpath #(
  parameter int DEPTH = sus_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  sus_pkg::req_t in_data,
  input  sus_pkg::cmd_t cmd,
  output sus_pkg::rsp_t out_data
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [sus_pkg::KEY_BITS-1:0] entries_r   [DEPTH];
  logic [sus_pkg::KEY_BITS-1:0] entries_nxt [DEPTH];
  logic [CNT_W-1:0]             count_r, count_nxt;
  sus_pkg::req_t                req_r;
  sus_pkg::rsp_t                rsp_r, rsp_nxt;

  logic [DEPTH-1:0] lt_vec, eq_vec, bnd_vec;
  logic [IDX_W-1:0] idx;
  logic             found, full, empty;
  logic             do_ins, do_del;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      lt_vec[i] = (CNT_W'(i) < count_r) && (entries_r[i] < req_r.key);
      eq_vec[i] = (CNT_W'(i) < count_r) && (entries_r[i] == req_r.key);
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 0) begin
        bnd_vec[i] = !lt_vec[i];
      end else begin
        bnd_vec[i] = lt_vec[i-1] && !lt_vec[i];
      end
    end
    idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (bnd_vec[i]) begin
        idx = idx | IDX_W'(i);
      end
    end
  end

  assign found = |eq_vec;
  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    rsp_nxt.status   = sus_pkg::ST_OK;
    rsp_nxt.position = sus_pkg::POS_BITS'(idx);
    do_ins           = 1'b0;
    do_del           = 1'b0;
    case (req_r.mode)
      sus_pkg::MODE_INSERT: begin
        if (found) begin
          rsp_nxt.status = sus_pkg::ST_DUP;
        end else if (full) begin
          rsp_nxt.status = sus_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      sus_pkg::MODE_DELETE: begin
        if (empty) begin
          rsp_nxt.status = sus_pkg::ST_EMPTY;
        end else if (!found) begin
          rsp_nxt.status = sus_pkg::ST_NOTFOUND;
        end else begin
          do_del = 1'b1;
        end
      end
      default: begin
        if (!found) begin
          rsp_nxt.status = sus_pkg::ST_NOTFOUND;
        end
      end
    endcase
    if (rsp_nxt.status != sus_pkg::ST_OK) begin
      rsp_nxt.position = '0;
    end
    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_del) begin
      count_nxt = count_r - CNT_W'(1);
    end
    rsp_nxt.count = sus_pkg::COUNT_BITS'(count_nxt);
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      entries_nxt[i] = entries_r[i];
      if (do_ins) begin
        if (bnd_vec[i]) begin
          entries_nxt[i] = req_r.key;
        end else if (!lt_vec[i] && i > 0) begin
          entries_nxt[i] = entries_r[i-1];
        end
      end else if (do_del) begin
        if (!lt_vec[i] && i + 1 < DEPTH) begin
          entries_nxt[i] = entries_r[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.execute) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data;
    end
    if (cmd.execute) begin
      rsp_r <= rsp_nxt;
      for (int i = 0; i < DEPTH; i++) begin
        entries_r[i] <= entries_nxt[i];
      end
    end
  end

  assign out_data = rsp_r;

endmodule

// ===== design/sorted_unique_set.sv =====
// Top level of the sorted unique key set: sequencer plus sorted register chain.
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+-----------------------------
//   in_     | input     | in_valid / in_ready  | req_t  {mode, key}
//   out_    | output    | out_valid / out_ready| rsp_t  {status, position, count}
//
// Each request first registers the word, then runs the parallel
// compare across all DEPTH entries and the shift of the register chain.
// A new word is taken while the previous result still waits in the output register;
// execution holds only while that register is full and out_ready is low.
// Reset (rst_n low, synchronous) empties the set; entry storage is not cleared.
module sorted_unique_set #(
  parameter int DEPTH = sus_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sus_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sus_pkg::rsp_t out_data
);

  sus_pkg::cmd_t cmd;

  sus_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  sus_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .out_data (out_data)
  );

endmodule
